### rtl/rybb_pkg.sv
// Shared types, constants and color-math helpers for the RGB to YCbCr block builder.
`timescale 1ns / 1ps
`default_nettype none

package rybb_pkg;

  localparam int unsigned BLOCK_SAMPLES_DEF = 64;

  // Width of the weighted sums: 255 * 256 fits in 16 bits plus sign.
  localparam int unsigned SUM_W = 18;

  // BT.601 integer weights, scaled by 256.
  localparam logic signed [SUM_W-1:0] W_Y_R  = 18'sd77;
  localparam logic signed [SUM_W-1:0] W_Y_G  = 18'sd150;
  localparam logic signed [SUM_W-1:0] W_Y_B  = 18'sd29;
  localparam logic signed [SUM_W-1:0] W_CB_R = -18'sd43;
  localparam logic signed [SUM_W-1:0] W_CB_G = -18'sd85;
  localparam logic signed [SUM_W-1:0] W_CB_B = 18'sd128;
  localparam logic signed [SUM_W-1:0] W_CR_R = 18'sd128;
  localparam logic signed [SUM_W-1:0] W_CR_G = -18'sd107;
  localparam logic signed [SUM_W-1:0] W_CR_B = -18'sd21;

  localparam logic signed [SUM_W-1:0] CHROMA_BIAS = 18'sd128;
  localparam logic signed [SUM_W-1:0] BYTE_MAX    = 18'sd255;
  localparam logic [7:0]              BIAS_BYTE   = 8'd128;

  // Packed store word: Y in the low byte, then Cb, then Cr.
  localparam int unsigned WORD_W = 24;

  typedef enum logic [0:0] {
    KIND_PIXEL = 1'b0,
    KIND_PULL  = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    BT_Y  = 2'd0,
    BT_CB = 2'd1,
    BT_CR = 2'd2
  } block_type_e;

  typedef enum logic [2:0] {
    PEND_NONE = 3'b000,
    PEND_CR   = 3'b100,
    PEND_CBCR = 3'b110,
    PEND_ALL  = 3'b111
  } pending_e;

  // Floor shift by 8, optional chroma bias, clamp to 0..255.
  function automatic logic [7:0] clamp_component(input logic signed [SUM_W-1:0] sum,
                                                 input logic add_bias);
    logic signed [SUM_W-1:0] sh;
    sh = (sum >>> 8) + (add_bias ? CHROMA_BIAS : 18'sd0);
    if (sh < 18'sd0) begin
      return 8'd0;
    end else if (sh > BYTE_MAX) begin
      return 8'hFF;
    end else begin
      return sh[7:0];
    end
  endfunction

endpackage

`default_nettype wire

### rtl/rybb_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module rybb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/rgb_to_ycbcr_block_builder_unit.sv
// Top level: RGB to YCbCr conversion with 8x8 block assembly and sample readout.
// Path: an accepted word moves through stage A, stage B and the output register.
// Throughput: one word per cycle unless the output stalls, pixels and pulls mixed
//   freely; the store's single write port and single registered read port set this.
// Reset (async, active low): fill count, pending flags, readout position and
//   pipeline valids clear; the block store contents stay undefined, no clear pass.
`timescale 1ns / 1ps
`default_nettype none

module rgb_to_ycbcr_block_builder_unit #(
  parameter int unsigned BLOCK_SAMPLES = rybb_pkg::BLOCK_SAMPLES_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // input channel
  input  wire logic              in_vld_i,
  output logic                   in_stall_o,
  input  wire logic              kind_i,
  input  wire logic [7:0]        red_i,
  input  wire logic [7:0]        green_i,
  input  wire logic [7:0]        blue_i,
  // output channel
  output logic                   out_vld_o,
  input  wire logic              out_stall_i,
  output logic                   pixel_taken_o,
  output logic                   sample_valid_o,
  output logic signed [8:0]      sample_o,
  output logic        [1:0]      block_type_o,
  output logic        [5:0]      element_index_o,
  output logic                   last_of_block_o
);

  localparam int unsigned IDX_W = $clog2(BLOCK_SAMPLES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BLOCK_SAMPLES - 1);
  localparam int unsigned SW = rybb_pkg::SUM_W;

  // Stage A: word accepted, store read in flight for pulls.
  typedef struct packed {
    logic                      taken;
    logic                      sval;
    rybb_pkg::block_type_e     phase;
    logic [IDX_W-1:0]          idx;
    logic                      last;
    logic [7:0]                r;
    logic [7:0]                g;
    logic [7:0]                b;
  } stage_a_t;

  // Stage B: weighted sums ready, pulled sample selected.
  typedef struct packed {
    logic                      taken;
    logic                      sval;
    rybb_pkg::block_type_e     phase;
    logic [IDX_W-1:0]          idx;
    logic                      last;
    logic signed [8:0]         smp;
    logic signed [SW-1:0]      y_sum;
    logic signed [SW-1:0]      cb_sum;
    logic signed [SW-1:0]      cr_sum;
  } stage_b_t;

  // ---------------------------------------------------------------------------
  // Control state: fill position, pending flags, readout position
  // ---------------------------------------------------------------------------
  logic [IDX_W-1:0]        fill_q, fill_d;
  rybb_pkg::pending_e      pending_q, pending_d;
  rybb_pkg::block_type_e   phase_q, phase_d;
  logic [IDX_W-1:0]        emit_idx_q, emit_idx_d;

  logic a_v_q, b_v_q, out_v_q;
  stage_a_t a_q, a_d;
  stage_b_t b_q, b_d;

  logic out_open, b_adv, a_adv, accept;
  logic busy;

  // Stall ripples back only through full stages, so bubbles soak it up.
  assign out_open   = !out_v_q || !out_stall_i;
  assign b_adv      = !b_v_q || out_open;
  assign a_adv      = !a_v_q || b_adv;
  assign in_stall_o = !a_adv;
  assign accept     = in_vld_i && a_adv;
  assign busy       = (pending_q != rybb_pkg::PEND_NONE);

  // Store ports
  logic                                ram_we, ram_re;
  logic [IDX_W-1:0]                    ram_waddr;
  logic [rybb_pkg::WORD_W-1:0]         ram_wdata, ram_rdata;
  logic [IDX_W-1:0]                    b_waddr_q;

  always_comb begin
    fill_d     = fill_q;
    pending_d  = pending_q;
    phase_d    = phase_q;
    emit_idx_d = emit_idx_q;
    ram_re     = 1'b0;

    a_d       = '0;
    a_d.phase = rybb_pkg::BT_Y;
    a_d.r     = red_i;
    a_d.g     = green_i;
    a_d.b     = blue_i;
    a_d.idx   = fill_q;

    if (accept) begin
      if (rybb_pkg::kind_e'(kind_i) == rybb_pkg::KIND_PIXEL) begin
        // Pixels are refused while any block still waits to be read out.
        if (!busy) begin
          a_d.taken = 1'b1;
          if (fill_q == LAST_IDX) begin
            fill_d     = '0;
            pending_d  = rybb_pkg::PEND_ALL;
            phase_d    = rybb_pkg::BT_Y;
            emit_idx_d = '0;
          end else begin
            fill_d = fill_q + 1'b1;
          end
        end
      end else if (busy) begin
        ram_re     = 1'b1;
        a_d.sval   = 1'b1;
        a_d.phase  = phase_q;
        a_d.idx    = emit_idx_q;
        a_d.last   = (emit_idx_q == LAST_IDX);
        if (emit_idx_q == LAST_IDX) begin
          emit_idx_d = '0;
          unique case (phase_q)
            rybb_pkg::BT_Y: begin
              phase_d   = rybb_pkg::BT_CB;
              pending_d = rybb_pkg::PEND_CBCR;
            end
            rybb_pkg::BT_CB: begin
              phase_d   = rybb_pkg::BT_CR;
              pending_d = rybb_pkg::PEND_CR;
            end
            default: begin
              phase_d   = rybb_pkg::BT_Y;
              pending_d = rybb_pkg::PEND_NONE;
            end
          endcase
        end else begin
          emit_idx_d = emit_idx_q + 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage A -> B: constant-weight sums, sample pick from the store word
  // ---------------------------------------------------------------------------
  logic signed [SW-1:0] r_s, g_s, b_s;
  logic [7:0]           pick;

  assign r_s = $signed({{(SW-8){1'b0}}, a_q.r});
  assign g_s = $signed({{(SW-8){1'b0}}, a_q.g});
  assign b_s = $signed({{(SW-8){1'b0}}, a_q.b});

  always_comb begin
    unique case (a_q.phase)
      rybb_pkg::BT_Y:  pick = ram_rdata[7:0];
      rybb_pkg::BT_CB: pick = ram_rdata[15:8];
      default:         pick = ram_rdata[23:16];
    endcase

    b_d        = '0;
    b_d.taken  = a_q.taken;
    b_d.sval   = a_q.sval;
    b_d.phase  = a_q.phase;
    b_d.idx    = a_q.idx;
    b_d.last   = a_q.last;
    b_d.y_sum  = rybb_pkg::W_Y_R * r_s + rybb_pkg::W_Y_G * g_s + rybb_pkg::W_Y_B * b_s;
    b_d.cb_sum = rybb_pkg::W_CB_R * r_s + rybb_pkg::W_CB_G * g_s + rybb_pkg::W_CB_B * b_s;
    b_d.cr_sum = rybb_pkg::W_CR_R * r_s + rybb_pkg::W_CR_G * g_s + rybb_pkg::W_CR_B * b_s;
    // Y is unsigned, chroma is stored already offset by -128.
    if (a_q.phase == rybb_pkg::BT_Y) begin
      b_d.smp = $signed({1'b0, pick});
    end else begin
      b_d.smp = $signed({pick[7], pick});
    end
  end

  // ---------------------------------------------------------------------------
  // Stage B -> output: shift, clamp, chroma offset, store write
  // ---------------------------------------------------------------------------
  logic [7:0] y_byte, cb_byte, cr_byte;

  assign y_byte  = rybb_pkg::clamp_component(b_q.y_sum, 1'b0);
  assign cb_byte = 8'(rybb_pkg::clamp_component(b_q.cb_sum, 1'b1) - rybb_pkg::BIAS_BYTE);
  assign cr_byte = 8'(rybb_pkg::clamp_component(b_q.cr_sum, 1'b1) - rybb_pkg::BIAS_BYTE);

  assign ram_we    = b_v_q && out_open && b_q.taken;
  assign ram_waddr = b_waddr_q;
  assign ram_wdata = {cr_byte, cb_byte, y_byte};

  // Low six bits of the position; zero-extended for small blocks.
  logic [IDX_W+5:0] idx_ext;
  assign idx_ext = {6'b0, b_q.idx};

  logic              taken_q, sval_q, last_q;
  logic signed [8:0] smp_q;
  logic [1:0]        btype_q;
  logic [5:0]        eidx_q;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q     <= '0;
      pending_q  <= rybb_pkg::PEND_NONE;
      phase_q    <= rybb_pkg::BT_Y;
      emit_idx_q <= '0;
      a_v_q      <= 1'b0;
      b_v_q      <= 1'b0;
      out_v_q    <= 1'b0;
    end else begin
      fill_q     <= fill_d;
      pending_q  <= pending_d;
      phase_q    <= phase_d;
      emit_idx_q <= emit_idx_d;
      if (a_adv)    a_v_q   <= in_vld_i;
      if (b_adv)    b_v_q   <= a_v_q;
      if (out_open) out_v_q <= b_v_q;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_q <= a_d;
    end
    if (b_adv && a_v_q) begin
      b_q       <= b_d;
      b_waddr_q <= a_q.idx;
    end
    if (out_open && b_v_q) begin
      taken_q <= b_q.taken;
      sval_q  <= b_q.sval;
      smp_q   <= b_q.sval ? b_q.smp : 9'sd0;
      btype_q <= b_q.sval ? b_q.phase : rybb_pkg::BT_Y;
      eidx_q  <= b_q.sval ? idx_ext[5:0] : 6'd0;
      last_q  <= b_q.sval && b_q.last;
    end
  end

  rybb_ram #(
    .WIDTH (rybb_pkg::WORD_W),
    .DEPTH (BLOCK_SAMPLES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (emit_idx_q),
    .rdata_o (ram_rdata)
  );

  assign out_vld_o       = out_v_q;
  assign pixel_taken_o   = taken_q;
  assign sample_valid_o  = sval_q;
  assign sample_o        = smp_q;
  assign block_type_o    = btype_q;
  assign element_index_o = eidx_q;
  assign last_of_block_o = last_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // Blocks drain in Y, Cb, Cr order, so only these flag patterns occur.
  a_pending_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q == rybb_pkg::PEND_NONE || pending_q == rybb_pkg::PEND_ALL ||
    pending_q == rybb_pkg::PEND_CBCR || pending_q == rybb_pkg::PEND_CR)
    else $error("pending flags out of order");

  // The fill position stays at zero while blocks are pending.
  a_fill_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> fill_q == '0)
    else $error("fill position moved while blocks pending");

  // Late pixel writes never hit the entry being read out.
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_re) |-> ram_waddr != emit_idx_q)
    else $error("store read and write collide");

  // A word is either a taken pixel or a sample, never both.
  a_one_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> !(taken_q && sval_q))
    else $error("pixel and sample flagged together");

  // Luma samples are never negative.
  a_luma_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && sval_q && btype_q == rybb_pkg::BT_Y) |-> !smp_q[8])
    else $error("negative luma sample");

endmodule

`default_nettype wire

### test/ycbcr_block_checker.sv
// Checker: predicts the YCbCr block builder's output words and compares them field by field.
`timescale 1ns / 1ps
`default_nettype none

module ycbcr_block_checker #(
  parameter int unsigned BLOCK_LEN = rybb_pkg::BLOCK_SAMPLES_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_vld_i,
  input  wire logic              in_stall_i,
  input  wire logic              kind_i,
  input  wire logic [7:0]        red_i,
  input  wire logic [7:0]        green_i,
  input  wire logic [7:0]        blue_i,
  input  wire logic              out_vld_i,
  input  wire logic              out_stall_i,
  input  wire logic              pixel_taken_i,
  input  wire logic              sample_valid_i,
  input  wire logic signed [8:0] sample_i,
  input  wire logic        [1:0] block_type_i,
  input  wire logic        [5:0] element_index_i,
  input  wire logic              last_of_block_i,
  output int                     errors_o,
  output int                     words_due_o
);

  typedef struct {
    logic                  taken;
    logic                  sample_ok;
    logic signed [8:0]     value;
    rybb_pkg::block_type_e btype;
    logic        [5:0]     pos;
    logic                  last;
  } ycc_word_t;

  // Block stores: Y as 0..255, Cb/Cr already offset by -128 (two's complement bytes).
  logic [7:0]            luma_mem [BLOCK_LEN];
  logic [7:0]            cb_mem   [BLOCK_LEN];
  logic [7:0]            cr_mem   [BLOCK_LEN];
  int unsigned           fill_cnt;
  int unsigned           read_idx;
  logic [2:0]            pend;
  rybb_pkg::block_type_e read_bt;
  ycc_word_t             ycc_q[$];
  int                    errs;

  function automatic logic [7:0] clamp_u8(input int v);
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return v[7:0];
  endfunction

  // Advances the model by one accepted word and returns the word it should produce.
  function automatic ycc_word_t predict_word(input logic k, input logic [7:0] r, g, b);
    ycc_word_t w;
    int ri, gi, bi;
    int sy, scb, scr;
    w.taken     = 1'b0;
    w.sample_ok = 1'b0;
    w.value     = '0;
    w.btype     = rybb_pkg::BT_Y;
    w.pos       = '0;
    w.last      = 1'b0;
    ri = r;
    gi = g;
    bi = b;
    if (k == rybb_pkg::KIND_PIXEL) begin
      // refused while any block still waits for readout
      if (pend == rybb_pkg::PEND_NONE && fill_cnt < BLOCK_LEN) begin
        sy  = 77 * ri + 150 * gi + 29 * bi;
        scb = -43 * ri - 85 * gi + 128 * bi;
        scr = 128 * ri - 107 * gi - 21 * bi;
        luma_mem[fill_cnt] = clamp_u8(sy >>> 8);
        cb_mem[fill_cnt]   = clamp_u8((scb >>> 8) + 128) - 8'd128;
        cr_mem[fill_cnt]   = clamp_u8((scr >>> 8) + 128) - 8'd128;
        fill_cnt++;
        if (fill_cnt >= BLOCK_LEN) begin
          fill_cnt = 0;
          pend     = rybb_pkg::PEND_ALL;
          read_bt  = rybb_pkg::BT_Y;
          read_idx = 0;
        end
        w.taken = 1'b1;
      end
    end else if (pend != rybb_pkg::PEND_NONE && read_idx < BLOCK_LEN) begin
      case (read_bt)
        rybb_pkg::BT_Y:  w.value = {1'b0, luma_mem[read_idx]};
        rybb_pkg::BT_CB: w.value = {cb_mem[read_idx][7], cb_mem[read_idx]};
        default:         w.value = {cr_mem[read_idx][7], cr_mem[read_idx]};
      endcase
      w.sample_ok = 1'b1;
      w.btype     = read_bt;
      w.pos       = read_idx[5:0];
      if (read_idx == BLOCK_LEN - 1) begin
        w.last        = 1'b1;
        pend[read_bt] = 1'b0;
        read_idx      = 0;
        case (read_bt)
          rybb_pkg::BT_Y:  read_bt = rybb_pkg::BT_CB;
          rybb_pkg::BT_CB: read_bt = rybb_pkg::BT_CR;
          default:         read_bt = rybb_pkg::BT_Y;
        endcase
      end else begin
        read_idx++;
      end
    end
    return w;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    ycc_word_t exp_w;
    if (!rst_ni) begin
      fill_cnt = 0;
      read_idx = 0;
      pend     = rybb_pkg::PEND_NONE;
      read_bt  = rybb_pkg::BT_Y;
      errs     = 0;
      ycc_q.delete();
      errors_o    <= 0;
      words_due_o <= 0;
    end else begin
      if (out_vld_i && !out_stall_i) begin
        if (ycc_q.size() == 0) begin
          $error("output word with nothing expected");
          errs++;
        end else begin
          exp_w = ycc_q.pop_front();
          if (pixel_taken_i !== exp_w.taken) begin
            $error("pixel_taken: expected %0d, got %0d", exp_w.taken, pixel_taken_i);
            errs++;
          end
          if (sample_valid_i !== exp_w.sample_ok) begin
            $error("sample_valid: expected %0d, got %0d", exp_w.sample_ok, sample_valid_i);
            errs++;
          end
          if (sample_i !== exp_w.value) begin
            $error("sample: expected %0d, got %0d", exp_w.value, sample_i);
            errs++;
          end
          if (block_type_i !== exp_w.btype) begin
            $error("block_type: expected %0d, got %0d", exp_w.btype, block_type_i);
            errs++;
          end
          if (element_index_i !== exp_w.pos) begin
            $error("element_index: expected %0d, got %0d", exp_w.pos, element_index_i);
            errs++;
          end
          if (last_of_block_i !== exp_w.last) begin
            $error("last_of_block: expected %0d, got %0d", exp_w.last, last_of_block_i);
            errs++;
          end
        end
      end
      if (in_vld_i && !in_stall_i) begin
        ycc_q.push_back(predict_word(kind_i, red_i, green_i, blue_i));
      end
      words_due_o <= ycc_q.size();
      errors_o    <= errs;
    end
  end

endmodule

`default_nettype wire

### test/rgb_to_ycbcr_block_builder_unit_tb.sv
// Testbench top: drives pixel and pull words into the block builder and reports the verdict.
`timescale 1ns / 1ps
`default_nettype none

module rgb_to_ycbcr_block_builder_unit_tb;

  localparam int unsigned BLK         = rybb_pkg::BLOCK_SAMPLES_DEF;
  localparam int          WORD_TARGET = 1500;    // useful words in the random part
  localparam int          PAUSE_AT    = 700;     // sender waits for a full drain here
  localparam int          CALM_FROM   = 900;     // no idling on either side in this window
  localparam int          CALM_TO     = 1200;
  localparam int          TAIL_CYCLES = 10;      // margin for stray words after the drain
  localparam int          CYCLE_LIMIT = 200000;

  logic            clk_i     = 1'b0;
  logic            rst_ni    = 1'b0;
  logic            in_vld    = 1'b0;
  rybb_pkg::kind_e kind_w    = rybb_pkg::KIND_PIXEL;
  logic [7:0]      red       = '0;
  logic [7:0]      green     = '0;
  logic [7:0]      blue      = '0;
  logic            out_stall = 1'b0;
  bit              calm      = 1'b0;
  int unsigned     cycle_cnt = 0;

  logic              in_stall;
  logic              out_vld;
  logic              pixel_taken;
  logic              sample_valid;
  logic signed [8:0] sample;
  logic        [1:0] block_type;
  logic        [5:0] element_index;
  logic              last_of_block;
  int                check_errors;
  int                words_due;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  rgb_to_ycbcr_block_builder_unit u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_vld_i        (in_vld),
    .in_stall_o      (in_stall),
    .kind_i          (kind_w),
    .red_i           (red),
    .green_i         (green),
    .blue_i          (blue),
    .out_vld_o       (out_vld),
    .out_stall_i     (out_stall),
    .pixel_taken_o   (pixel_taken),
    .sample_valid_o  (sample_valid),
    .sample_o        (sample),
    .block_type_o    (block_type),
    .element_index_o (element_index),
    .last_of_block_o (last_of_block)
  );

  ycbcr_block_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_vld_i        (in_vld),
    .in_stall_i      (in_stall),
    .kind_i          (kind_w),
    .red_i           (red),
    .green_i         (green),
    .blue_i          (blue),
    .out_vld_i       (out_vld),
    .out_stall_i     (out_stall),
    .pixel_taken_i   (pixel_taken),
    .sample_valid_i  (sample_valid),
    .sample_i        (sample),
    .block_type_i    (block_type),
    .element_index_i (element_index),
    .last_of_block_i (last_of_block),
    .errors_o        (check_errors),
    .words_due_o     (words_due)
  );

  // Receiver backpressure: ~19% of cycles, none inside the calm window.
  always @(posedge clk_i) begin
    out_stall <= !calm && ($urandom_range(99) < 19);
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Mostly uniform, but pins a component to 0 or 255 one time in four.
  function automatic logic [7:0] pick_level();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Offers one word and returns at the edge it is taken. An optional idle gap goes first
  // (gaps on ~9% of words, ~19% idle cycles); valid stays high between back-to-back
  // words, so no double assignment in one step.
  task automatic send_word(input rybb_pkg::kind_e k, input logic [7:0] r, g, b);
    if (!calm && $urandom_range(99) < 9) begin
      in_vld <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    in_vld <= 1'b1;
    kind_w <= k;
    red    <= r;
    green  <= g;
    blue   <= b;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  // Color corners: black, white, primaries, mid and near-black grays, and the mixes
  // that pin Cb/Cr to their extremes (yellow drives Cb to -128, cyan drives Cr to -128).
  logic [23:0] corner_px [10] = '{24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00,
                                  24'h0000FF, 24'hFFFF00, 24'h00FFFF, 24'hFF00FF,
                                  24'h808080, 24'h010101};

  initial begin
    int              pix_fill;     // pixels taken into the block being filled
    int              pulls_owed;   // samples still waiting for readout
    int              useful;
    bit              paused;
    rybb_pkg::kind_e odd_kind;
    pix_fill   = 0;
    pulls_owed = 0;
    useful     = 0;
    paused     = 1'b0;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: pull on an empty builder (pixel fields ignored), color corners,
    // pulls in between that must come back empty.
    send_word(rybb_pkg::KIND_PULL, 8'hFF, 8'hFF, 8'hFF);
    foreach (corner_px[i]) begin
      send_word(rybb_pkg::KIND_PIXEL, corner_px[i][23:16], corner_px[i][15:8],
                corner_px[i][7:0]);
      if (i == 4) begin
        send_word(rybb_pkg::KIND_PULL, 8'h5A, 8'hA5, 8'h00);
      end
    end
    send_word(rybb_pkg::KIND_PULL, 8'h00, 8'h00, 8'h00);
    pix_fill = $size(corner_px);

    // Random: complete fill/readout cycles with random pixel content. Now and then a
    // short run of the wrong kind goes in: pixels while blocks are pending (refused)
    // and pulls while filling (empty). Those runs are not counted as useful words.
    while (useful < WORD_TARGET) begin
      calm = (useful >= CALM_FROM && useful < CALM_TO);
      if (useful == PAUSE_AT && !paused) begin
        // let the pipe run dry before going on
        paused = 1'b1;
        in_vld <= 1'b0;
        @(posedge clk_i);
        while (words_due != 0) @(posedge clk_i);
      end
      if ($urandom_range(99) < 8) begin
        odd_kind = (pulls_owed > 0) ? rybb_pkg::KIND_PIXEL : rybb_pkg::KIND_PULL;
        repeat ($urandom_range(6, 1)) begin
          send_word(odd_kind, pick_level(), pick_level(), pick_level());
        end
      end else begin
        if (pulls_owed > 0) begin
          send_word(rybb_pkg::KIND_PULL, pick_level(), pick_level(), pick_level());
          pulls_owed--;
        end else begin
          send_word(rybb_pkg::KIND_PIXEL, pick_level(), pick_level(), pick_level());
          pix_fill++;
          if (pix_fill == BLK) begin
            pix_fill   = 0;
            pulls_owed = 3 * BLK;
          end
        end
        useful++;
      end
    end
    calm = 1'b0;

    // Drain: wait for every expected word, then a few cycles for strays.
    in_vld <= 1'b0;
    @(posedge clk_i);
    while (words_due != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (check_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire

### files.f
rtl/rybb_pkg.sv
rtl/rybb_ram.sv
rtl/rgb_to_ycbcr_block_builder_unit.sv
test/ycbcr_block_checker.sv
test/rgb_to_ycbcr_block_builder_unit_tb.sv
